// File: src/afd_pkg.sv
`default_nettype none

package afd_pkg;

    localparam logic signed [15:0] RAIL_POS = 16'sd32000;
    localparam logic signed [15:0] RAIL_NEG = -16'sd32000;

    localparam logic [3:0] RAILED_POLLS = 4'd12;
    localparam logic [3:0] COUNT_MAX    = 4'd15;

    localparam int unsigned RESET_BACKOFF_US = 5000000;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;
    localparam int ACCEL_BITS     = 48;
    localparam int OUT_BITS       = 24;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UP_AXIS          = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UP_NEGATIVE      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FLIP_THRESHOLD   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FLIP_VOTES       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MOTION_THRESHOLD = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MOTION_HOLD_US   = 3'd5;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } accel_t;

    typedef struct packed {
        logic [1:0]  up_axis;
        logic        up_negative;
        logic [14:0] flip_threshold;
        logic [3:0]  flip_votes;
        logic [17:0] motion_threshold;
        logic [23:0] motion_hold_us;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        up_axis:          2'd1,
        up_negative:      1'b1,
        flip_threshold:   15'd3500,
        flip_votes:       4'd3,
        motion_threshold: 18'd220,
        motion_hold_us:   24'd1000000
    };

    typedef struct packed {
        logic [17:0] motion;
        logic        moving;
        logic        handled;
    } motion_res_t;

    typedef struct packed {
        logic inverted;
        logic reset_request;
        logic up_railed;
    } orient_res_t;

    function automatic logic is_railed(input logic signed [15:0] x);
        return (x <= RAIL_NEG) || (x >= RAIL_POS);
    endfunction

    // absolute change of one axis, zero when either reading is railed
    function automatic logic [16:0] axis_change(input logic signed [15:0] a,
                                                input logic signed [15:0] p);
        logic signed [16:0] d;
        d = $signed({a[15], a}) - $signed({p[15], p});
        if (is_railed(a) || is_railed(p))
        begin
            return 17'd0;
        end
        return d[16] ? 17'(-d) : 17'(d);
    endfunction

endpackage

`default_nettype wire

// File: src/afd_motion.sv
`default_nettype none

module afd_motion #(
    parameter int TIME_BITS = 48
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         en,
    input  afd_pkg::cfg_t               cfg,
    input  afd_pkg::accel_t             accel,
    input  wire [TIME_BITS-1:0]         now,
    output afd_pkg::motion_res_t        res
);

    afd_pkg::accel_t        prev_reg;
    afd_pkg::accel_t        prev_next;
    logic                   have_prev_reg;
    logic                   have_prev_next;
    logic                   prev_moved_reg;
    logic                   prev_moved_next;
    logic [17:0]            last_motion_reg;
    logic [17:0]            last_motion_next;
    logic [TIME_BITS-1:0]   moved_time_reg;
    logic [TIME_BITS-1:0]   moved_time_next;
    logic [TIME_BITS-1:0]   handled_time_reg;
    logic [TIME_BITS-1:0]   handled_time_next;

    logic [17:0]            sum;
    logic                   moved;

    // a zero stamp means never
    function automatic logic held(input logic [TIME_BITS-1:0] stamp,
                                  input logic [TIME_BITS-1:0] t,
                                  input logic [23:0] hold);
        logic [TIME_BITS-1:0] elapsed;
        elapsed = t - stamp;
        return (stamp != '0) && (elapsed < TIME_BITS'(hold));
    endfunction

    always_comb
    begin
        sum = 18'(afd_pkg::axis_change(accel.x, prev_reg.x))
            + 18'(afd_pkg::axis_change(accel.y, prev_reg.y))
            + 18'(afd_pkg::axis_change(accel.z, prev_reg.z));
        moved = sum > cfg.motion_threshold;

        prev_next         = accel;
        have_prev_next    = 1'b1;
        prev_moved_next   = prev_moved_reg;
        last_motion_next  = last_motion_reg;
        moved_time_next   = moved_time_reg;
        handled_time_next = handled_time_reg;

        if (have_prev_reg)
        begin
            last_motion_next = sum;
            prev_moved_next  = moved;
            if (moved)
            begin
                moved_time_next = now;
            end
            if (moved && prev_moved_reg)
            begin
                handled_time_next = now;
            end
        end

        res.motion  = last_motion_next;
        res.moving  = held(moved_time_next, now, cfg.motion_hold_us);
        res.handled = held(handled_time_next, now, cfg.motion_hold_us);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg         <= '0;
            have_prev_reg    <= 1'b0;
            prev_moved_reg   <= 1'b0;
            last_motion_reg  <= '0;
            moved_time_reg   <= '0;
            handled_time_reg <= '0;
        end
        else if (en)
        begin
            prev_reg         <= prev_next;
            have_prev_reg    <= have_prev_next;
            prev_moved_reg   <= prev_moved_next;
            last_motion_reg  <= last_motion_next;
            moved_time_reg   <= moved_time_next;
            handled_time_reg <= handled_time_next;
        end
    end

endmodule

`default_nettype wire

// File: src/afd_orient.sv
`default_nettype none

module afd_orient #(
    parameter int TIME_BITS = 48
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         en,
    input  afd_pkg::cfg_t               cfg,
    input  afd_pkg::accel_t             accel,
    input  wire [TIME_BITS-1:0]         now,
    output afd_pkg::orient_res_t        res
);

    logic                   inverted_reg;
    logic                   inverted_next;
    logic [3:0]             streak_reg;
    logic [3:0]             streak_next;
    logic [3:0]             railed_cnt_reg;
    logic [3:0]             railed_cnt_next;
    logic [TIME_BITS-1:0]   gate_reg;
    logic [TIME_BITS-1:0]   gate_next;

    logic signed [15:0]     a_up;
    logic signed [15:0]     other;
    logic                   up_bad;
    logic                   req;
    logic signed [16:0]     v;
    logic signed [16:0]     other_ext;
    logic signed [16:0]     thr;
    logic signed [16:0]     neg_thr;
    logic [16:0]            mag_v;
    logic [16:0]            mag_o;
    logic                   dominant;
    logic                   wants;
    logic [3:0]             streak_inc;
    logic [3:0]             railed_inc;

    always_comb
    begin
        case (cfg.up_axis)
            afd_pkg::AXIS_X:
            begin
                a_up  = accel.x;
                other = accel.y;
            end
            afd_pkg::AXIS_Y:
            begin
                a_up  = accel.y;
                other = accel.x;
            end
            default:
            begin
                a_up  = accel.z;
                other = accel.x;
            end
        endcase

        up_bad    = afd_pkg::is_railed(a_up);
        v         = cfg.up_negative ? -$signed({a_up[15], a_up}) : $signed({a_up[15], a_up});
        other_ext = $signed({other[15], other});
        mag_v     = v[16] ? 17'(-v) : 17'(v);
        mag_o     = other_ext[16] ? 17'(-other_ext) : 17'(other_ext);
        thr       = $signed({2'b00, cfg.flip_threshold});
        neg_thr   = -thr;
        dominant  = afd_pkg::is_railed(other) || (mag_v > mag_o);
        wants     = dominant && (inverted_reg ? (v > thr) : (v < neg_thr));

        streak_inc = (streak_reg == afd_pkg::COUNT_MAX) ? streak_reg : streak_reg + 4'd1;
        railed_inc = (railed_cnt_reg == afd_pkg::COUNT_MAX) ? railed_cnt_reg
                                                            : railed_cnt_reg + 4'd1;

        inverted_next   = inverted_reg;
        streak_next     = streak_reg;
        railed_cnt_next = railed_cnt_reg;
        gate_next       = gate_reg;
        req             = 1'b0;

        if (up_bad)
        begin
            railed_cnt_next = railed_inc;
            if ((railed_inc >= afd_pkg::RAILED_POLLS) && (now > gate_reg))
            begin
                req             = 1'b1;
                railed_cnt_next = 4'd0;
                gate_next       = now + TIME_BITS'(afd_pkg::RESET_BACKOFF_US);
            end
        end
        else
        begin
            railed_cnt_next = 4'd0;
            streak_next     = wants ? streak_inc : 4'd0;
            if (streak_next >= cfg.flip_votes)
            begin
                inverted_next = !inverted_reg;
                streak_next   = 4'd0;
            end
        end

        res.inverted      = inverted_next;
        res.reset_request = req;
        res.up_railed     = up_bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverted_reg   <= 1'b0;
            streak_reg     <= '0;
            railed_cnt_reg <= '0;
            gate_reg       <= '0;
        end
        else if (en)
        begin
            inverted_reg   <= inverted_next;
            streak_reg     <= streak_next;
            railed_cnt_reg <= railed_cnt_next;
            gate_reg       <= gate_next;
        end
    end

endmodule

`default_nettype wire

// File: src/accel_orientation_flip_detector.sv
// path: an accepted sample loads the input register, then moves to the result register
// once that is empty or its result is taken; throughput: one sample per cycle while
// the output is not stalled; all state updates in the single stage between the input
// register and the result register; a result not taken holds the input
// reset: rst_n is asynchronous, active low; clears the valid flags of both stages,
// all detector state and loads the default register values
`default_nettype none

module accel_orientation_flip_detector #(
    parameter int TIME_BITS = 48
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    s_axis_tvalid,
    output logic                                   s_axis_tready,
    // accel_x, accel_y, accel_z, time_us, zero pad
    input  wire [((afd_pkg::ACCEL_BITS+TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire                                    m_axis_tready,
    // inverted, motion, moving, handled, reset_request, up_railed, zero pad
    output logic [afd_pkg::OUT_BITS-1:0]           m_axis_tdata,
    input  wire                                    cfg_we,
    input  wire [afd_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  wire [afd_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

    afd_pkg::cfg_t          cfg_reg;
    afd_pkg::cfg_t          cfg_next;

    logic                   in_valid_reg;
    logic                   in_valid_next;
    afd_pkg::accel_t        in_accel_reg;
    logic [TIME_BITS-1:0]   in_time_reg;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [afd_pkg::OUT_BITS-1:0] out_data_reg;
    logic [afd_pkg::OUT_BITS-1:0] out_data_next;

    logic                   s_fire;
    logic                   advance;

    afd_pkg::motion_res_t   motion_res;
    afd_pkg::orient_res_t   orient_res;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    afd_motion #(
        .TIME_BITS (TIME_BITS)
    ) u_motion (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .cfg   (cfg_reg),
        .accel (in_accel_reg),
        .now   (in_time_reg),
        .res   (motion_res)
    );

    afd_orient #(
        .TIME_BITS (TIME_BITS)
    ) u_orient (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .cfg   (cfg_reg),
        .accel (in_accel_reg),
        .now   (in_time_reg),
        .res   (orient_res)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                afd_pkg::REG_UP_AXIS:          cfg_next.up_axis = cfg_data[1:0];
                afd_pkg::REG_UP_NEGATIVE:      cfg_next.up_negative = cfg_data[0];
                afd_pkg::REG_FLIP_THRESHOLD:   cfg_next.flip_threshold = cfg_data[14:0];
                afd_pkg::REG_FLIP_VOTES:       cfg_next.flip_votes = cfg_data[3:0];
                afd_pkg::REG_MOTION_THRESHOLD: cfg_next.motion_threshold = cfg_data[17:0];
                afd_pkg::REG_MOTION_HOLD_US:   cfg_next.motion_hold_us = cfg_data[23:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        out_data_next = {1'b0, orient_res.up_railed, orient_res.reset_request,
                         motion_res.handled, motion_res.moving, motion_res.motion,
                         orient_res.inverted};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= afd_pkg::CFG_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_accel_reg <= s_axis_tdata[afd_pkg::ACCEL_BITS-1:0];
            in_time_reg  <= s_axis_tdata[afd_pkg::ACCEL_BITS +: TIME_BITS];
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    a_req_needs_rail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[21] |-> m_axis_tdata[22])
        else $error("reset request without railed up axis");

    a_stalled_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_time_reg)
                                     && $stable(in_accel_reg))
        else $error("stalled sample lost or changed");

    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("processed sample produced no result");

endmodule

`default_nettype wire
